// ===== design/tkl_pkg.sv =====
// shared types and constants for the top-k leaderboard
`default_nettype none
package tkl_pkg;

  // result status codes
  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_MOVED     = 3'd1;
  localparam logic [2:0] ST_NOT_IMPR  = 3'd2;
  localparam logic [2:0] ST_NOT_RANK  = 3'd3;
  localparam logic [2:0] ST_BAD_LIST  = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE = 3'd5;
  localparam logic [2:0] ST_ENTRY     = 3'd6;

  // configuration register indexes
  localparam logic CFG_MASK = 1'b0;
  localparam logic CFG_MAX  = 1'b1;

  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam int MAX_READ = 16;

  // datapath memory operation
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;        // capture input transaction
    mem_op_t op;          // memory operation this cycle
    logic    wr_from_rd;  // write data is the registered read data, else new pair
    logic    addr_sel;    // 0 use rd pointer, 1 use wr pointer
    logic    ptr_inc;     // advance pointer
    logic    ptr_dec;     // step pointer down
    logic    ptr_load;    // load pointer from count minus one / found slot
    logic    note_scan;   // evaluate registered read data for scan
    logic    cnt_write;   // store new entry count
    logic    out_load;    // capture result
    logic [2:0] out_status;
    logic    out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic valid_list;
    logic too_large;
    logic action;
    logic ptr_at_count; // scan pointer reached count
    logic read_limit;   // read-out reached its result cap
    logic found;        // user seen during scan
    logic improves;     // key beats stored key of found user
    logic full_reject;  // insert slot at list length
    logic shift_done;   // shift pointer reached target
    logic empty;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/tkl_datapath.sv =====
// leaderboard storage, scan pointers, compares and result register
`default_nettype none
module tkl_datapath import tkl_pkg::*; #(
  parameter int LIST_COUNT  = 16,
  parameter int LIST_LENGTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_list,
  input  wire logic [31:0] in_user,
  input  wire logic [31:0] in_score,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic [2:0]       r_status,
  output logic [4:0]       r_rank,
  output logic [31:0]      r_user,
  output logic [31:0]      r_score,
  output logic [4:0]       r_count,
  output logic             r_last
);
  localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int PW = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;
  localparam int CW = $clog2(LIST_LENGTH + 1);
  localparam int DEPTH = LIST_COUNT * LIST_LENGTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] mask;
  logic [31:0] max_score;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      max_score <= '1;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MASK) mask <= cfg_data[15:0];
      else max_score <= cfg_data;
    end
  end

  // captured transaction
  logic        action;
  logic [LW-1:0] idx;
  logic [31:0] user, score, key;
  logic        valid_list, too_large, inv;
  logic [7:0]  lm1;
  assign lm1 = in_list - 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action     <= in_action;
      idx        <= lm1[LW-1:0];
      user       <= in_user;
      score      <= in_score;
      valid_list <= (in_list != 8'd0) && ({24'd0, in_list} <= 32'(LIST_COUNT));
      too_large  <= in_score > max_score;
      inv        <= (lm1 < 8'd16) && mask[lm1[3:0]];
      key        <= ((lm1 < 8'd16) && mask[lm1[3:0]]) ? max_score - in_score : in_score;
    end
  end

  // per-list entry counts, valid bits stand in for reset
  logic [CW-1:0] counts [LIST_COUNT];
  logic [LIST_COUNT-1:0] cvalid;
  logic [CW-1:0] count, new_count;
  assign count = cvalid[idx] ? counts[idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) cvalid <= '0;
    else if (cmd.cnt_write) cvalid[idx] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.cnt_write) counts[idx] <= new_count;
  end

  // pointers: rd scans, wr marks the slot to write
  logic [CW-1:0] ptr;
  logic [CW-1:0] slot;
  logic          found;
  logic [CW-1:0] fpos;
  logic [31:0]   fkey;
  logic          ins_set;
  logic [CW-1:0] ins;

  // memories
  logic [31:0] keys_mem  [DEPTH];
  logic [31:0] users_mem [DEPTH];
  logic [31:0] rd_key, rd_user;
  logic [CW-1:0] rd_ptr;
  logic [AW-1:0] addr;
  logic [CW-1:0] aptr;
  assign aptr = cmd.addr_sel ? slot : ptr;
  assign addr = AW'(idx) * AW'(LIST_LENGTH) + AW'(aptr[PW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.op == MEM_WRITE) begin
      keys_mem[addr]  <= cmd.wr_from_rd ? rd_key  : key;
      users_mem[addr] <= cmd.wr_from_rd ? rd_user : user;
    end
    if (cmd.op == MEM_READ) begin
      rd_key  <= keys_mem[addr];
      rd_user <= users_mem[addr];
      rd_ptr  <= ptr;
    end
  end

  // scan and pointer bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr     <= '0;
      found   <= 1'b0;
      ins_set <= 1'b0;
    end else begin
      if (cmd.note_scan) begin
        if (rd_user == user && !found) begin
          found <= 1'b1;
          fpos  <= rd_ptr;
          fkey  <= rd_key;
        end
        if (rd_key < key && !ins_set) begin
          ins_set <= 1'b1;
          ins     <= rd_ptr;
        end
      end
      if (cmd.ptr_load) begin
        // start of shift: slot is the hole to fill
        if (found) slot <= fpos;
        else if (count < CW'(LIST_LENGTH)) slot <= count;
        else slot <= CW'(LIST_LENGTH - 1);
        ptr <= found ? fpos - 1'b1
                     : ((count < CW'(LIST_LENGTH)) ? count : CW'(LIST_LENGTH - 1)) - 1'b1;
      end else if (cmd.ptr_dec) begin
        ptr  <= ptr - 1'b1;
        slot <= slot - 1'b1;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  logic [CW-1:0] ins_pos;
  assign ins_pos = ins_set ? ins : count;

  // target of the shift: moving user stops where key no longer beats
  logic [CW-1:0] target;
  always_comb begin
    if (found) target = (ins_set && ins < fpos) ? ins : fpos;
    else target = ins_pos;
  end

  assign new_count = (count < CW'(LIST_LENGTH)) ? count + 1'b1 : count;

  assign stat.valid_list   = valid_list;
  assign stat.too_large    = too_large;
  assign stat.action       = action;
  assign stat.ptr_at_count = ptr >= count;
  assign stat.read_limit   = (32'(ptr) >= MAX_READ);
  assign stat.found        = found;
  assign stat.improves     = key > fkey;
  assign stat.full_reject  = !found && (32'(ins_pos) >= 32'(LIST_LENGTH));
  assign stat.shift_done   = (slot == target);
  assign stat.empty        = (count == '0);

  // result register
  logic [31:0] raw;
  assign raw = inv ? max_score - rd_key : rd_key;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      r_status <= cmd.out_status;
      r_last   <= cmd.out_last;
      r_count  <= 5'(count);
      r_rank   <= '0;
      r_user   <= user;
      r_score  <= score;
      case (cmd.out_status)
        ST_ENTRY: begin
          r_rank  <= 5'(rd_ptr);
          r_user  <= rd_user;
          r_score <= raw;
        end
        ST_NEW, ST_MOVED: r_rank <= 5'(target);
        ST_NOT_IMPR: r_rank <= 5'(fpos);
        ST_NOT_RANK: r_rank <= '0;
        ST_BAD_LIST: begin
          r_user  <= '0;
          r_score <= '0;
          r_count <= '0;
        end
        ST_TOO_LARGE: begin
          r_user  <= '0;
          r_score <= '0;
          if (!valid_list) r_count <= '0;
        end
        default: r_rank <= '0;
      endcase
      if (cmd.out_status == ST_NEW) r_count <= 5'(new_count);
    end
  end

  // a count never exceeds the list length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_write |=> (32'(counts[$past(idx)]) <= 32'(LIST_LENGTH)))
    else $error("entry count above list length");
  // a memory write never addresses a slot beyond the list length
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == MEM_WRITE) |-> (32'(aptr) < 32'(LIST_LENGTH)))
    else $error("write beyond list");
  // a new transaction is never captured during memory work
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (cmd.op == MEM_NONE && !cmd.cnt_write))
    else $error("load overlaps memory work");
endmodule
`default_nettype wire

// ===== design/tkl_ctrl.sv =====
// sequencer for submit and read transactions
`default_nettype none
module tkl_ctrl import tkl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire stat_t stat,
  output cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECIDE = 10'b0000000010,
    S_SRD    = 10'b0000000100,
    S_SCHK   = 10'b0000001000,
    S_PLAN   = 10'b0000010000,
    S_SHRD   = 10'b0000100000,
    S_SHWR   = 10'b0001000000,
    S_PUT    = 10'b0010000000,
    S_RRD    = 10'b0100000000,
    S_RSEND  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_pend, out_pend_next;
  assign out_valid = out_pend;
  assign in_ready = (state == S_IDLE) && !out_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= out_pend_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd = '0;
    state_next = state;
    out_pend_next = out_pend && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.action == ACT_READ) begin
          if (!stat.valid_list) begin
            cmd.out_load = 1'b1; cmd.out_status = ST_BAD_LIST; cmd.out_last = 1'b1;
            out_pend_next = 1'b1; state_next = S_IDLE;
          end else if (stat.empty) state_next = S_IDLE;
          else state_next = S_RRD;
        end else if (stat.too_large) begin
          cmd.out_load = 1'b1; cmd.out_status = ST_TOO_LARGE; cmd.out_last = 1'b1;
          out_pend_next = 1'b1; state_next = S_IDLE;
        end else if (!stat.valid_list) begin
          cmd.out_load = 1'b1; cmd.out_status = ST_BAD_LIST; cmd.out_last = 1'b1;
          out_pend_next = 1'b1; state_next = S_IDLE;
        end else if (stat.empty) state_next = S_PLAN;
        else state_next = S_SRD;
      end
      // scan pass: read one entry, then evaluate it before the next read
      S_SRD: begin
        cmd.op = MEM_READ; cmd.ptr_inc = 1'b1; state_next = S_SCHK;
      end
      S_SCHK: begin
        cmd.note_scan = 1'b1;
        state_next = stat.ptr_at_count ? S_PLAN : S_SRD;
      end
      S_PLAN: begin
        if (stat.found && !stat.improves) begin
          cmd.out_load = 1'b1; cmd.out_status = ST_NOT_IMPR; cmd.out_last = 1'b1;
          out_pend_next = 1'b1; state_next = S_IDLE;
        end else if (stat.full_reject) begin
          cmd.out_load = 1'b1; cmd.out_status = ST_NOT_RANK; cmd.out_last = 1'b1;
          out_pend_next = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.ptr_load = 1'b1; state_next = S_SHRD;
        end
      end
      // shift pass: move entries down one slot until the target
      S_SHRD: begin
        if (stat.shift_done) state_next = S_PUT;
        else begin
          cmd.op = MEM_READ; state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.op = MEM_WRITE; cmd.addr_sel = 1'b1; cmd.wr_from_rd = 1'b1;
        cmd.ptr_dec = 1'b1; state_next = S_SHRD;
      end
      S_PUT: begin
        cmd.op = MEM_WRITE; cmd.addr_sel = 1'b1;
        cmd.out_load = 1'b1; cmd.out_last = 1'b1;
        cmd.out_status = stat.found ? ST_MOVED : ST_NEW;
        cmd.cnt_write = !stat.found;
        out_pend_next = 1'b1; state_next = S_IDLE;
      end
      // read-out: one entry per result, wait for the output slot
      S_RRD: begin
        if (!out_pend || out_ready) begin
          cmd.op = MEM_READ; cmd.ptr_inc = 1'b1; state_next = S_RSEND;
        end
      end
      S_RSEND: begin
        cmd.out_load = 1'b1; cmd.out_status = ST_ENTRY;
        cmd.out_last = stat.ptr_at_count || stat.read_limit;
        out_pend_next = 1'b1;
        state_next = cmd.out_last ? S_IDLE : S_RRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_pend && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while stalled");
  // input only accepted when idle and drained
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (state == S_IDLE && !out_pend))
    else $error("input taken while busy");
  // every submit ends with a result loaded before idle
  a_put_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> out_pend)
    else $error("submit ended with no result");
endmodule
`default_nettype wire

// ===== design/top_k_leaderboard.sv =====
// top level of the top-k leaderboard
// Usage: items enter on the s_axis channel (tdata: list_number, user_id,
// score; tuser: action). Results leave on m_axis (tdata: rank, entry_user,
// entry_score, entry_count; tuser: status; tlast: last).
// A submit scans the list one entry at a time (read, then compare), then
// shifts entries down one at a time (read, then write) and finally writes
// the new or moved entry into the slot that the shift left free.
// A read emits one result per stored entry, pausing until the output is
// free; an empty list gives nothing and the block returns to idle.
// The block holds one item at a time; s_axis_tready is high only when idle
// with no pending result. A stalled receiver holds the result register and
// the read-out pauses until it is taken.
// Configuration: cfg_we, cfg_idx, cfg_data; write only while idle.
// Reset clears configuration to defaults and all list counts to zero at
// once; stored entries need no clearing since only entries below a count
// are read.
`default_nettype none
module top_k_leaderboard import tkl_pkg::*; #(
  parameter int LIST_COUNT  = 16,
  parameter int LIST_LENGTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // list_number[7:0], user_id[39:8], score[71:40]
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // rank[4:0], entry_user[36:5], entry_score[68:37], entry_count[73:69]
  output logic [2:0]       m_axis_tuser,  // status
  output logic             m_axis_tlast   // last
);
  cmd_t  cmd;
  stat_t stat;
  logic [4:0] r_rank, r_count;
  logic [31:0] r_user, r_score;
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  tkl_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .stat, .cmd
  );

  tkl_datapath #(.LIST_COUNT(LIST_COUNT), .LIST_LENGTH(LIST_LENGTH)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_action(s_axis_tuser), .in_list(s_axis_tdata[7:0]),
    .in_user(s_axis_tdata[39:8]), .in_score(s_axis_tdata[71:40]),
    .cmd, .stat, .r_status(m_axis_tuser), .r_rank, .r_user, .r_score,
    .r_count, .r_last(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, r_count, r_score, r_user, r_rank};
endmodule
`default_nettype wire

// ===== test/top_k_leaderboard_test.sv =====
// testbench for the top-k leaderboard: scoreboard prediction, random stimulus and idling
`default_nettype none

class leaderboard_scoreboard;
  logic [15:0] mask;
  logic [31:0] max_sc;
  logic [31:0] keys [16][16];
  logic [31:0] users [16][16];
  int counts [16];
  logic [2:0] exp_status [$];
  logic [4:0] exp_rank [$];
  logic [31:0] exp_user [$];
  logic [31:0] exp_score [$];
  logic [4:0] exp_count [$];
  logic exp_last [$];
  int errors;
  int results_seen;

  function new();
    mask = 16'h0;
    max_sc = 32'hFFFF_FFFF;
    errors = 0;
    results_seen = 0;
    foreach (counts[i]) counts[i] = 0;
  endfunction

  function void push(logic [2:0] st, int rk, logic [31:0] u, logic [31:0] sc, int cnt,
                     logic lst);
    exp_status.push_back(st);
    exp_rank.push_back(rk[4:0]);
    exp_user.push_back(u);
    exp_score.push_back(sc);
    exp_count.push_back(cnt[4:0]);
    exp_last.push_back(lst);
  endfunction

  // predict the results of one accepted input transaction
  function void note_item(logic act, logic [7:0] list, logic [31:0] u, logic [31:0] sc);
    bit ok;
    int idx;
    int n;
    int p;
    int i;
    logic [31:0] key;
    bit inv;
    ok = (list >= 1 && list <= 16);
    idx = ok ? list - 1 : 0;
    inv = ok && mask[idx];
    if (act == tkl_pkg::ACT_READ) begin
      if (!ok) begin
        push(tkl_pkg::ST_BAD_LIST, 0, 0, 0, 0, 1'b1);
        return;
      end
      n = counts[idx];
      for (i = 0; i < n; i++)
        push(tkl_pkg::ST_ENTRY, i, users[idx][i], inv ? max_sc - keys[idx][i] : keys[idx][i],
             n, i + 1 == n);
      return;
    end
    if (sc > max_sc) begin
      push(tkl_pkg::ST_TOO_LARGE, 0, 0, 0, ok ? counts[idx] : 0, 1'b1);
      return;
    end
    if (!ok) begin
      push(tkl_pkg::ST_BAD_LIST, 0, 0, 0, 0, 1'b1);
      return;
    end
    key = inv ? max_sc - sc : sc;
    n = counts[idx];
    for (p = 0; p < n; p++)
      if (users[idx][p] == u) break;
    if (p < n) begin
      if (key <= keys[idx][p]) begin
        push(tkl_pkg::ST_NOT_IMPR, p, u, sc, n, 1'b1);
        return;
      end
      i = p;
      while (i > 0 && key > keys[idx][i-1]) begin
        keys[idx][i] = keys[idx][i-1];
        users[idx][i] = users[idx][i-1];
        i--;
      end
      keys[idx][i] = key;
      users[idx][i] = u;
      push(tkl_pkg::ST_MOVED, i, u, sc, n, 1'b1);
      return;
    end
    for (p = 0; p < n && keys[idx][p] >= key; p++) ;
    if (p >= 16) begin
      push(tkl_pkg::ST_NOT_RANK, 0, u, sc, n, 1'b1);
      return;
    end
    if (n < 16) n++;
    for (i = n - 1; i > p; i--) begin
      keys[idx][i] = keys[idx][i-1];
      users[idx][i] = users[idx][i-1];
    end
    keys[idx][p] = key;
    users[idx][p] = u;
    counts[idx] = n;
    push(tkl_pkg::ST_NEW, p, u, sc, n, 1'b1);
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(logic [79:0] d, logic [2:0] st, logic lst);
    logic [2:0] es;
    logic [4:0] er;
    logic [31:0] eu;
    logic [31:0] esc;
    logic [4:0] ec;
    logic el;
    results_seen++;
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected result status %0d data %h", $time, st, d);
      errors++;
      return;
    end
    es = exp_status.pop_front();
    er = exp_rank.pop_front();
    eu = exp_user.pop_front();
    esc = exp_score.pop_front();
    ec = exp_count.pop_front();
    el = exp_last.pop_front();
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st); errors++;
    end
    if (d[4:0] !== er) begin
      $display("%0t: rank expected %0d actual %0d", $time, er, d[4:0]); errors++;
    end
    if (d[36:5] !== eu) begin
      $display("%0t: user expected %h actual %h", $time, eu, d[36:5]); errors++;
    end
    if (d[68:37] !== esc) begin
      $display("%0t: score expected %h actual %h", $time, esc, d[68:37]); errors++;
    end
    if (d[73:69] !== ec) begin
      $display("%0t: count expected %0d actual %0d", $time, ec, d[73:69]); errors++;
    end
    if (d[79:74] !== 6'd0) begin
      $display("%0t: pad expected 0 actual %h", $time, d[79:74]); errors++;
    end
    if (lst !== el) begin
      $display("%0t: last expected %0d actual %0d", $time, el, lst); errors++;
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module top_k_leaderboard_test;
  import tkl_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = 1'b0;
  logic [31:0] cfg_data = 32'd0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = 72'd0;  // list_number, user_id, score
  logic s_axis_tuser = 1'b0;          // action
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;          // rank, entry_user, entry_score, entry_count
  logic [2:0] m_axis_tuser;           // status
  logic m_axis_tlast;

  leaderboard_scoreboard board;
  bit calm = 1'b0;        // no idling on either side
  bit stall_go = 1'b0;    // request for the long receiver hold-off
  bit stall_taken = 1'b0; // hold-off already started
  int hold_left = 0;      // receiver stall cycles remaining
  int sent = 0;
  logic [31:0] user_pool [8];

  top_k_leaderboard u_top (.*);

  always #4 clk = ~clk;

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (stall_go && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // offer one transaction; valid stays up until the next gap or drain
  task automatic send_item(logic act, logic [7:0] list, logic [31:0] u, logic [31:0] sc);
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {sc, u, list};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(act, list, u, sc);
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // a submit that yields nothing extra may still be finishing
    while (guard < 60) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MASK) board.mask = val[15:0];
    else board.max_sc = val;
    @(posedge clk);
  endtask

  task automatic random_item(int small_max);
    logic [7:0] list;
    logic [31:0] u;
    logic [31:0] sc;
    int r;
    r = $urandom_range(99);
    list = (r < 6) ? 8'($urandom) : 8'($urandom_range(16, 1));
    u = ($urandom_range(3) != 0) ? user_pool[$urandom_range(7)] : $urandom;
    if (small_max != 0) sc = $urandom_range(small_max + 3);
    else sc = ($urandom_range(1) != 0) ? $urandom : $urandom_range(40);
    send_item(($urandom_range(99) < 15) ? ACT_READ : ACT_SUBMIT, list, u, sc);
  endtask

  initial begin
    int i;
    board = new();
    foreach (user_pool[k]) user_pool[k] = $urandom;
    user_pool[0] = 32'hFFFF_FFFF;
    user_pool[1] = 32'h0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every status but too-large, tie insertion, full list, bad lists
    send_item(ACT_READ, 8'd1, 0, 0);
    send_item(ACT_SUBMIT, 8'd0, 32'h5, 32'h9);
    send_item(ACT_READ, 8'd0, 0, 0);
    send_item(ACT_READ, 8'd255, 0, 0);
    send_item(ACT_SUBMIT, 8'd17, 32'h5, 32'hFFFF_FFFF);
    send_item(ACT_SUBMIT, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_SUBMIT, 8'd1, 32'h0, 32'd0);
    send_item(ACT_SUBMIT, 8'd1, 32'h7, 32'd100);
    send_item(ACT_SUBMIT, 8'd1, 32'h8, 32'd100);
    send_item(ACT_SUBMIT, 8'd1, 32'h8, 32'd50);
    send_item(ACT_SUBMIT, 8'd1, 32'h0, 32'd200);
    send_item(ACT_READ, 8'd1, 0, 0);
    for (i = 0; i < 16; i++) send_item(ACT_SUBMIT, 8'd16, 32'h100 + i, 32'd10 + i);
    send_item(ACT_SUBMIT, 8'd16, 32'h999, 32'd10);
    send_item(ACT_READ, 8'd16, 0, 0);
    drain();

    // inverted lists with a small max score
    write_cfg(CFG_MASK, 32'h0000_FFFF);
    write_cfg(CFG_MAX, 32'd20);
    send_item(ACT_SUBMIT, 8'd0, 32'h1, 32'd21);
    send_item(ACT_SUBMIT, 8'd2, 32'h1, 32'd21);
    send_item(ACT_SUBMIT, 8'd2, 32'h1, 32'd20);
    send_item(ACT_SUBMIT, 8'd2, 32'h2, 32'd0);
    send_item(ACT_READ, 8'd1, 0, 0);
    drain();

    // receiver holds off while the sender keeps offering
    calm = 1'b1;
    stall_go = 1'b1;
    for (i = 0; i < 20; i++) send_item(ACT_SUBMIT, 8'd3, user_pool[i % 8], $urandom_range(20));
    send_item(ACT_READ, 8'd3, 0, 0);
    drain();
    calm = 1'b0;

    // random phases over several settings
    write_cfg(CFG_MASK, 32'h0);
    write_cfg(CFG_MAX, 32'hFFFF_FFFF);
    for (i = 0; i < 40; i++) random_item(0);
    drain();
    write_cfg(CFG_MASK, {16'd0, 16'($urandom)});
    write_cfg(CFG_MAX, 32'd30);
    for (i = 0; i < 40; i++) random_item(30);
    drain();
    calm = 1'b1;
    write_cfg(CFG_MAX, 32'd0);
    for (i = 0; i < 20; i++) random_item(1);
    drain();
    calm = 1'b0;
    write_cfg(CFG_MASK, 32'h0000_A5A5);
    write_cfg(CFG_MAX, $urandom);
    for (i = 0; i < 50; i++) random_item(0);
    for (i = 1; i <= 16; i++) send_item(ACT_READ, 8'(i), 0, 0);
    drain();

    $display("sent %0d items, checked %0d results across inverted and plain lists",
             sent, board.results_seen);
    $display("covered bad lists, oversize scores, ties, full lists and long stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ===== top_k_leaderboard.f =====
design/tkl_pkg.sv
design/tkl_datapath.sv
design/tkl_ctrl.sv
design/top_k_leaderboard.sv
test/top_k_leaderboard_test.sv
